// ===== rtl/ipdad_pkg.sv =====
// Package for the IPv6 duplicate address detection table.
// Transfer types, entry types and codes shared by all files. No dependencies.
package ipdad_pkg;

  localparam int unsigned SLOTS_DFLT = 8;

  localparam logic [15:0] DAD_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  PREFIX_MAX      = 8'd128;
  localparam logic [9:0]  LINK_LOCAL_PFX  = 10'h3FA;

  localparam logic [1:0] OP_CONFIG  = 2'd0;
  localparam logic [1:0] OP_ADVERT  = 2'd1;
  localparam logic [1:0] OP_DUP_SOL = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [2:0] RS_OK      = 3'd0;
  localparam logic [2:0] RS_INVALID = 3'd1;
  localparam logic [2:0] RS_EXISTS  = 3'd2;
  localparam logic [2:0] RS_FULL    = 3'd3;
  localparam logic [2:0] RS_NOMATCH = 3'd4;

  localparam logic [1:0] ES_NONE      = 2'd0;
  localparam logic [1:0] ES_TENTATIVE = 2'd1;
  localparam logic [1:0] ES_ENABLED   = 2'd2;
  localparam logic [1:0] ES_CONFLICT  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_length;
    logic [2:0]  slot_index;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_used;
    logic       leave_multicast;
    logic [7:0] promoted_mask;
    logic       send_router_solicit;
  } result_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [15:0] countdown;
    logic        armed;
  } ctl_entry_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix;
  } addr_entry_t;

endpackage

// ===== rtl/ipdad_addr_mem.sv =====
// Address store: one synchronous RAM of address and prefix per slot.
// Depends on ipdad_pkg. Contents are undefined until written.
module ipdad_addr_mem import ipdad_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DFLT,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic        clk_i,
  input  logic        rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output addr_entry_t rd_data_o,
  input  logic        wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  addr_entry_t wr_data_i
);

  addr_entry_t mem_q [SLOTS];
  addr_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/ipdad_ctl_mem.sv =====
// Control store: state, countdown and armed flag per slot in a synchronous RAM.
// Depends on ipdad_pkg. Per-slot valid flops make unwritten slots read as reset.
module ipdad_ctl_mem import ipdad_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DFLT,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output ctl_entry_t    rd_data_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  ctl_entry_t    wr_data_i
);

  ctl_entry_t mem_q [SLOTS];
  ctl_entry_t rd_q;
  logic [SLOTS-1:0] valid_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/ipdad_seq.sv =====
// Sequencer: sweeps all slots once per item, read-modify-write on the stores.
// Depends on ipdad_pkg. Drives ipdad_ctl_mem and ipdad_addr_mem ports.
module ipdad_seq import ipdad_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DFLT,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  item_t         item_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output result_t       result_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  output logic          rd_en_o,
  output logic [IW-1:0] rd_addr_o,
  input  ctl_entry_t    ctl_rd_i,
  input  addr_entry_t   addr_rd_i,
  output logic          ctl_we_o,
  output logic [IW-1:0] ctl_waddr_o,
  output ctl_entry_t    ctl_wdata_o,
  output logic          addr_we_o,
  output logic [IW-1:0] addr_waddr_o,
  output addr_entry_t   addr_wdata_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [1:0]    state_q, state_d;
  item_t         item_q, item_d;
  logic [IW-1:0] ev_q, ev_d;
  logic          exists_q, exists_d;
  logic          open_fnd_q, open_fnd_d;
  logic [IW-1:0] open_q, open_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [7:0]    mask_q, mask_d;
  logic          rs_q, rs_d;
  result_t       res_q, res_d;
  logic          res_vld_q, res_vld_d;
  logic [15:0]   timeout_q;

  logic [6:0] ev_w, sidx_w, open_w, slot_w;
  logic       addr_eq, cfg_ok;

  assign ev_w    = {{(7-IW){1'b0}}, ev_q};
  assign open_w  = {{(7-IW){1'b0}}, open_q};
  assign slot_w  = {{(7-IW){1'b0}}, slot_q};
  assign sidx_w  = {4'd0, item_q.slot_index};
  assign addr_eq = (addr_rd_i.addr_high == item_q.address_high) &&
                   (addr_rd_i.addr_low == item_q.address_low);
  assign cfg_ok  = item_q.is_ipv6 && (item_q.prefix_length != 8'd0) &&
                   (item_q.prefix_length <= PREFIX_MAX);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    ev_d         = ev_q;
    exists_d     = exists_q;
    open_fnd_d   = open_fnd_q;
    open_d       = open_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    mask_d       = mask_q;
    rs_d         = rs_q;
    res_d        = res_q;
    res_vld_d    = 1'b0;
    rd_en_o      = 1'b0;
    rd_addr_o    = '0;
    ctl_we_o     = 1'b0;
    ctl_waddr_o  = ev_q;
    ctl_wdata_o  = ctl_rd_i;
    addr_we_o    = 1'b0;
    addr_waddr_o = open_q;
    addr_wdata_o = '{addr_high: item_q.address_high, addr_low: item_q.address_low,
                     prefix: item_q.prefix_length};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rd_en_o    = 1'b1;
          item_d     = item_i;
          ev_d       = '0;
          exists_d   = 1'b0;
          open_fnd_d = 1'b0;
          open_d     = '0;
          hit_d      = 1'b0;
          slot_d     = '0;
          mask_d     = '0;
          rs_d       = 1'b0;
          state_d    = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (ev_q != LAST) begin
          rd_en_o   = 1'b1;
          rd_addr_o = IW'(ev_w + 7'd1);
          ev_d      = IW'(ev_w + 7'd1);
        end else begin
          state_d = S_FIN;
        end
        unique case (item_q.operation)
          OP_CONFIG: begin
            if (ctl_rd_i.state != ES_NONE) begin
              if (addr_eq) begin
                exists_d = 1'b1;
              end
            end else if (!open_fnd_q) begin
              open_fnd_d = 1'b1;
              open_d     = ev_q;
            end
          end
          OP_ADVERT, OP_DUP_SOL: begin
            if (!hit_q && ctl_rd_i.state == ES_TENTATIVE &&
                ((item_q.operation == OP_ADVERT) ? addr_eq : (sidx_w == ev_w))) begin
              ctl_we_o    = 1'b1;
              ctl_wdata_o = '{state: ES_CONFLICT, countdown: 16'd0, armed: 1'b0};
              hit_d       = 1'b1;
              slot_d      = ev_q;
            end
          end
          OP_TICK: begin
            if (ctl_rd_i.armed) begin
              ctl_we_o = 1'b1;
              if (ctl_rd_i.countdown <= 16'd1) begin
                ctl_wdata_o.countdown = 16'd0;
                ctl_wdata_o.armed     = 1'b0;
                if (ctl_rd_i.state == ES_TENTATIVE) begin
                  ctl_wdata_o.state = ES_ENABLED;
                  if (ev_w < 7'd8) begin
                    mask_d[ev_w[2:0]] = 1'b1;
                  end
                  if (addr_rd_i.addr_high[63:54] == LINK_LOCAL_PFX) begin
                    rs_d = 1'b1;
                  end
                end
              end else begin
                ctl_wdata_o.countdown = ctl_rd_i.countdown - 16'd1;
              end
            end
          end
        endcase
      end
      S_FIN: begin
        res_vld_d = 1'b1;
        res_d     = '0;
        state_d   = S_IDLE;
        unique case (item_q.operation)
          OP_CONFIG: begin
            if (!cfg_ok) begin
              res_d.status = RS_INVALID;
            end else if (exists_q) begin
              res_d.status = RS_EXISTS;
            end else if (!open_fnd_q) begin
              res_d.status = RS_FULL;
            end else begin
              res_d.status    = RS_OK;
              res_d.slot_used = open_w[2:0];
              ctl_we_o        = 1'b1;
              ctl_waddr_o     = open_q;
              ctl_wdata_o     = '{state: ES_TENTATIVE, countdown: timeout_q, armed: 1'b1};
              addr_we_o       = 1'b1;
            end
          end
          OP_ADVERT, OP_DUP_SOL: begin
            if (hit_q) begin
              res_d.status          = RS_OK;
              res_d.slot_used       = slot_w[2:0];
              res_d.leave_multicast = (item_q.operation == OP_ADVERT);
            end else begin
              res_d.status = RS_NOMATCH;
            end
          end
          OP_TICK: begin
            res_d.status              = RS_OK;
            res_d.promoted_mask       = mask_q;
            res_d.send_router_solicit = rs_q;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_vld_q <= 1'b0;
      timeout_q <= DAD_TIMEOUT_RST;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ev_q       <= ev_d;
    exists_q   <= exists_d;
    open_fnd_q <= open_fnd_d;
    open_q     <= open_d;
    hit_q      <= hit_d;
    slot_q     <= slot_d;
    mask_q     <= mask_d;
    rs_q       <= rs_d;
    res_q      <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/ipv6_dad_address_table.sv =====
// Top level of the IPv6 address table with duplicate address detection.
// Depends on ipdad_pkg, ipdad_seq, ipdad_ctl_mem and ipdad_addr_mem.
//
// Command channel: item_i is transferred on a rising edge with start high
// and busy low. Operations: configure address, neighbor advert, dup
// solicit on a slot, millisecond tick.
// Result channel: result_o is shown for exactly one cycle with
// result_valid_o high; the receiver takes it then and cannot stall.
// Config: cfg_we_i writes cfg_wdata_i into the DAD timeout register
// (reset 1000 ticks); write only while no command is in flight.
// Timing: every command sweeps the slots once through the control and
// address RAMs, one slot per cycle, set by the single read port of each
// RAM. The result strobe follows the sweep, state S_FIN and the result
// register; busy drops in that same cycle, so commands never overlap.
// Reset: all slots read as empty and unarmed at once (per-slot valid bits);
// the table is usable in the first cycle after reset.
module ipv6_dad_address_table import ipdad_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  item_t       item_i,
  output logic        busy,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  ctl_entry_t    ctl_rd;
  addr_entry_t   addr_rd;
  logic          ctl_we;
  logic [IW-1:0] ctl_waddr;
  ctl_entry_t    ctl_wdata;
  logic          addr_we;
  logic [IW-1:0] addr_waddr;
  addr_entry_t   addr_wdata;

  ipdad_seq #(.SLOTS(SLOTS), .IW(IW)) u_seq (
    .clk_i, .rst_ni, .item_i, .result_valid_o, .result_o,
    .start_i      (start),
    .busy_o       (busy),
    .cfg_we_i, .cfg_wdata_i,
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .ctl_rd_i     (ctl_rd),
    .addr_rd_i    (addr_rd),
    .ctl_we_o     (ctl_we),
    .ctl_waddr_o  (ctl_waddr),
    .ctl_wdata_o  (ctl_wdata),
    .addr_we_o    (addr_we),
    .addr_waddr_o (addr_waddr),
    .addr_wdata_o (addr_wdata)
  );

  ipdad_ctl_mem #(.SLOTS(SLOTS), .IW(IW)) u_ctl_mem (
    .clk_i, .rst_ni,
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ctl_rd),
    .wr_en_i   (ctl_we),
    .wr_addr_i (ctl_waddr),
    .wr_data_i (ctl_wdata)
  );

  ipdad_addr_mem #(.SLOTS(SLOTS), .IW(IW)) u_addr_mem (
    .clk_i,
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (addr_rd),
    .wr_en_i   (addr_we),
    .wr_addr_i (addr_waddr),
    .wr_data_i (addr_wdata)
  );

endmodule

// ===== rtl/ipdad_checker.sv =====
// Port-level checks for ipv6_dad_address_table, attached by bind.
// Depends on ipdad_pkg.
module ipdad_checker import ipdad_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    result_valid_o,
  input result_t result_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !result_valid_o))
    else $error("command transfer not followed by busy");

  a_idle_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("busy while result shown");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.status == RS_OK || result_o.status == RS_INVALID ||
                        result_o.status == RS_EXISTS || result_o.status == RS_FULL ||
                        result_o.status == RS_NOMATCH))
    else $error("undefined status code");

  a_leave_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.leave_multicast) |->
      (result_o.status == RS_OK && result_o.promoted_mask == 8'd0 &&
       !result_o.send_router_solicit))
    else $error("leave request mixed with tick or failure");

endmodule

bind ipv6_dad_address_table ipdad_checker u_ipdad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_o         (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
